@@ rtl/core/bmd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types, constants and register codes for the background motion
// detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bmd_pkg;

  // default parameter values
  localparam int BG_DEPTH_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 8;

  localparam int PIX_W   = 8;   // one colour component
  localparam int DIM_W   = 12;  // frame size registers
  localparam int CNT_W   = 11;  // row and column counters
  localparam int SCALE_W = 3;
  localparam int IDX_W   = 12;  // cell_index field
  localparam int SUM_W   = 10;  // sum of three components
  localparam int CFG_W   = 12;  // widest register
  localparam int CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;

  // x / 3 for x < 1536 as (x * 683) >> 11
  localparam int DIV3_MUL_W = 20;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 20'd683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

  // register reset values
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 12'd480;
  localparam logic [SCALE_W-1:0] RST_SCALE_LOG2   = 3'd4;
  localparam logic [PIX_W-1:0]   RST_ADAPT_STEP   = 8'd26;
  localparam logic [PIX_W-1:0]   RST_BRIGHT_TH    = 8'd20;
  localparam logic [PIX_W-1:0]   RST_COLOUR_TH    = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_SCALE_LOG2   = 3'd2,
    CFG_ADAPT_STEP   = 3'd3,
    CFG_BRIGHT_TH    = 3'd4,
    CFG_COLOUR_TH    = 3'd5
  } cfg_reg_t;

  // element 0 red, 1 green, 2 blue
  typedef logic [2:0][PIX_W-1:0] pixel_t;

  // per-cell tags that ride along the pipeline
  typedef struct packed {
    logic             learning;
    logic             untracked;
    logic             last;
    logic [IDX_W-1:0] index;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bmd_ram.sv @@
// ----------------------------------------------------------------------------
// bmd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bmd_scan.sv @@
// ----------------------------------------------------------------------------
// bmd_scan
// Raster position tracking: row, column and cell counters, subsampling
// decision and the store address of the current cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_scan #(
  parameter int BG_DEPTH = bmd_pkg::BG_DEPTH_DEF,
  localparam int AW = $clog2(BG_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          frame_start,
  input  logic [bmd_pkg::DIM_W-1:0]     frame_width,
  input  logic [bmd_pkg::DIM_W-1:0]     frame_height,
  input  logic [bmd_pkg::SCALE_W-1:0]   scale_log2,
  output logic                          sampled,
  output logic [AW-1:0]                 addr,
  output bmd_pkg::cell_ctrl_t           ctrl
);

  import bmd_pkg::*;

  localparam int CCW = $clog2(BG_DEPTH + 1);
  localparam logic [CCW-1:0] DEPTH_C = CCW'(BG_DEPTH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > MAX_DIM) begin
      return MAX_DIM;
    end
    return v;
  endfunction

  logic [CNT_W-1:0] row_count, column_count, row_count_next, column_count_next;
  logic [CNT_W-1:0] row_cur, col_cur;
  logic [CCW-1:0]   cell_count, cell_count_next, cell_cur;
  logic             first_frame, first_frame_next;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [7:0]       sf;
  logic [6:0]       msk;
  logic             tracked, row_end, col_end;

  assign w_eff    = clamp_dim(frame_width);
  assign h_eff    = clamp_dim(frame_height);
  assign sf       = 8'd1 << scale_log2;
  assign msk      = 7'(sf - 8'd1);

  assign row_cur  = frame_start ? '0 : row_count;
  assign col_cur  = frame_start ? '0 : column_count;
  assign cell_cur = frame_start ? '0 : cell_count;

  assign sampled  = ((row_cur[6:0] & msk) == '0) && ((col_cur[6:0] & msk) == '0);
  assign tracked  = cell_cur < DEPTH_C;
  assign addr     = AW'(cell_cur);

  assign col_end  = ({1'b0, col_cur} + DIM_W'(1)) >= w_eff;
  assign row_end  = ({1'b0, row_cur} + DIM_W'(1)) >= h_eff;

  always_comb begin
    ctrl.learning  = first_frame;
    ctrl.untracked = !tracked;
    ctrl.last      = (({1'b0, row_cur} + DIM_W'(sf)) >= h_eff) &&
                     (({1'b0, col_cur} + DIM_W'(sf)) >= w_eff);
    ctrl.index     = tracked ? IDX_W'(cell_cur) : '0;
  end

  always_comb begin
    column_count_next = col_cur + CNT_W'(1);
    row_count_next    = row_cur;
    cell_count_next   = (sampled && tracked) ? cell_cur + CCW'(1) : cell_cur;
    first_frame_next  = first_frame;
    if (col_end) begin
      column_count_next = '0;
      if (row_end) begin
        row_count_next   = '0;
        cell_count_next  = '0;
        first_frame_next = 1'b0;
      end else begin
        row_count_next = row_cur + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
      cell_count   <= '0;
      first_frame  <= 1'b1;
    end else if (accept) begin
      row_count    <= row_count_next;
      column_count <= column_count_next;
      cell_count   <= cell_count_next;
      first_frame  <= first_frame_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bmd_update.sv @@
// ----------------------------------------------------------------------------
// bmd_update
// Background store and read-modify-write stage: reads the cell's background,
// steps each channel toward the pixel, or loads it if learning; writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_update #(
  parameter int BG_DEPTH  = bmd_pkg::BG_DEPTH_DEF,
  parameter int FRAC_BITS = bmd_pkg::FRAC_BITS_DEF,
  localparam int AW  = $clog2(BG_DEPTH),
  localparam int CHW = bmd_pkg::PIX_W + FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [AW-1:0]          load_addr,
  input  bmd_pkg::cell_ctrl_t    load_ctrl,
  input  bmd_pkg::pixel_t        load_pix,
  input  logic [CHW-1:0]         step,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_take,
  output logic [2:0][CHW-1:0]    out_bg,
  output bmd_pkg::cell_ctrl_t    out_ctrl,
  output bmd_pkg::pixel_t        out_pix
);

  import bmd_pkg::*;

  localparam int BGW = 3 * CHW;
  localparam logic [CHW-1:0] TOP = CHW'(255) << FRAC_BITS;

  logic             s1_valid;
  logic [AW-1:0]    s1_addr;
  cell_ctrl_t       s1_ctrl;
  pixel_t           s1_pix;

  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [BGW-1:0]   fwd_data;

  logic [BGW-1:0]   ram_rdata;
  logic [2:0][CHW-1:0] bg_cur, bg_new;
  logic             adv, wr_en;

  assign adv      = s1_valid && out_take;
  assign can_load = !s1_valid || out_take;
  assign wr_en    = adv && !s1_ctrl.untracked;

  bmd_ram #(
    .WIDTH (BGW),
    .DEPTH (BG_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (bg_new),
    .rd_en   (load && !load_ctrl.untracked),
    .rd_addr (load_addr),
    .rd_data (ram_rdata)
  );

  // the previous cell's write lands on the same edge as this cell's read
  assign bg_cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;

  always_comb begin
    logic [CHW-1:0] p;
    for (int c = 0; c < 3; c++) begin
      p = {s1_pix[c], {FRAC_BITS{1'b0}}};
      bg_new[c] = bg_cur[c];
      if (s1_ctrl.learning) begin
        bg_new[c] = p;
      end else if (p > bg_cur[c] && bg_cur[c] < TOP) begin
        bg_new[c] = bg_cur[c] + step;
      end else if (p < bg_cur[c] && bg_cur[c] != '0) begin
        bg_new[c] = (bg_cur[c] > step) ? bg_cur[c] - step : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (can_load) begin
        s1_valid <= load;
      end
      if (wr_en) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      s1_addr <= load_addr;
      s1_ctrl <= load_ctrl;
      s1_pix  <= load_pix;
    end
    if (wr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= bg_new;
    end
  end

  assign out_valid = s1_valid;
  assign out_bg    = bg_new;
  assign out_ctrl  = s1_ctrl;
  assign out_pix   = s1_pix;

endmodule

`default_nettype wire

@@ rtl/core/bmd_eval.sv @@
// ----------------------------------------------------------------------------
// bmd_eval
// Change measurement against the updated background: channel differences,
// colour and brightness change, thresholds and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_eval #(
  parameter int FRAC_BITS = bmd_pkg::FRAC_BITS_DEF,
  localparam int CHW = bmd_pkg::PIX_W + FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         can_load,
  input  logic [2:0][CHW-1:0]          in_bg,
  input  bmd_pkg::cell_ctrl_t          in_ctrl,
  input  bmd_pkg::pixel_t              in_pix,
  input  logic [bmd_pkg::PIX_W-1:0]    bright_threshold,
  input  logic [bmd_pkg::PIX_W-1:0]    colour_threshold,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [bmd_pkg::PIX_W-1:0]    movement,
  output bmd_pkg::cell_ctrl_t          res_ctrl
);

  import bmd_pkg::*;

  localparam int SW = CHW + 2;   // sum of three backgrounds
  localparam int DW = 10;        // signed channel difference
  localparam int CW = 11;        // colour change before saturation

  // stage A: updated background and pixel
  logic                a_valid;
  logic [2:0][CHW-1:0] a_bg;
  cell_ctrl_t          a_ctrl;
  pixel_t              a_pix;

  // stage B: differences, brightness magnitude and pixel sum
  logic                       b_valid;
  logic signed [2:0][DW-1:0]  b_d;
  logic [SUM_W-1:0]           b_mag;
  logic [SUM_W-1:0]           b_sum;
  cell_ctrl_t                 b_ctrl;

  logic a_move, b_move, o_load;
  logic signed [2:0][DW-1:0] d_a;
  logic [SUM_W-1:0]          sum_a, mag_a;
  logic [SW-1:0]             bgsum_a, psum_a, mag_full;

  logic [CW-1:0]             colch;
  logic [PIX_W-1:0]          colch_sat, mean, brch;
  logic [DIV3_MUL_W-1:0]     prod_b, prod_m;
  logic [PIX_W-1:0]          movement_next;

  assign o_load   = !res_valid || !res_stall;
  assign b_move   = b_valid && o_load;
  assign a_move   = a_valid && (!b_valid || o_load);
  assign can_load = !a_valid || !b_valid || o_load;

  // channel difference truncated toward zero
  always_comb begin
    logic [CHW-1:0] p, dm;
    for (int c = 0; c < 3; c++) begin
      p  = {a_pix[c], {FRAC_BITS{1'b0}}};
      dm = (p >= a_bg[c]) ? p - a_bg[c] : a_bg[c] - p;
      d_a[c] = (p >= a_bg[c]) ? DW'(dm >> FRAC_BITS)
                              : DW'(0) - DW'(dm >> FRAC_BITS);
    end
  end

  assign sum_a    = SUM_W'(a_pix[0]) + SUM_W'(a_pix[1]) + SUM_W'(a_pix[2]);
  assign bgsum_a  = SW'(a_bg[0]) + SW'(a_bg[1]) + SW'(a_bg[2]);
  assign psum_a   = {sum_a, {FRAC_BITS{1'b0}}};
  assign mag_full = (psum_a >= bgsum_a) ? psum_a - bgsum_a : bgsum_a - psum_a;
  assign mag_a    = SUM_W'(mag_full >> FRAC_BITS);

  function automatic logic [CW-1:0] abs_diff(input logic signed [DW-1:0] x,
                                             input logic signed [DW-1:0] y);
    logic signed [CW-1:0] t;
    t = CW'(x) - CW'(y);
    return (t < 0) ? CW'(-t) : CW'(t);
  endfunction

  assign colch     = abs_diff(b_d[0], b_d[1]) + abs_diff(b_d[1], b_d[2]) +
                     abs_diff(b_d[2], b_d[0]);
  assign colch_sat = (colch > CW'(SAT_MAX)) ? SAT_MAX : PIX_W'(colch);
  assign prod_b    = DIV3_MUL_W'(b_mag) * DIV3_MUL;
  assign prod_m    = DIV3_MUL_W'(b_sum) * DIV3_MUL;
  assign brch      = PIX_W'(prod_b >> DIV3_SHIFT);
  assign mean      = PIX_W'(prod_m >> DIV3_SHIFT);

  assign movement_next = (!b_ctrl.learning && !b_ctrl.untracked &&
                          colch_sat > colour_threshold && brch > bright_threshold)
                         ? mean : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (can_load) begin
        a_valid <= in_valid;
      end
      if (!b_valid || o_load) begin
        b_valid <= a_valid;
      end
      if (o_load) begin
        res_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && can_load) begin
      a_bg   <= in_bg;
      a_ctrl <= in_ctrl;
      a_pix  <= in_pix;
    end
    if (a_move) begin
      b_d    <= d_a;
      b_mag  <= mag_a;
      b_sum  <= sum_a;
      b_ctrl <= a_ctrl;
    end
    if (b_move) begin
      movement <= movement_next;
      res_ctrl <= b_ctrl;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/background_motion_detector_top.sv @@
// ----------------------------------------------------------------------------
// background_motion_detector_top
// Background-subtraction motion detector on a subsampled RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (pix_valid/pix_stall, frame_start, red, green, blue) takes
//   one pixel per transaction in raster order; frame_start restarts the
//   row/column counters. Only pixels on the 2^scale_log2 grid give a result.
//   Result channel (res_valid/res_stall) carries one transaction per sampled
//   pixel: movement, cell_index, learning, untracked, frame_last.
//   Throughput: one pixel per cycle unless res_stall has filled the pipeline.
//   Each tracked sampled cell is one read-modify-write of the background
//   RAM; back-to-back cells on the same entry are served from a forwarding
//   register. Path from an accepted pixel to its result: RAM read, eval input
//   register, difference stage, threshold stage with result register.
//   Stall: res_stall holds the result register; bubbles in the pipeline are
//   filled first, and pix_stall rises only when every stage holds a cell.
//   Reset: counters cleared, first frame marked as learning, registers take
//   their defaults. The background RAM is not cleared; the first frame
//   loads it. Configuration writes are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module background_motion_detector_top #(
  parameter int BG_DEPTH  = bmd_pkg::BG_DEPTH_DEF,
  parameter int FRAC_BITS = bmd_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [bmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmd_pkg::CFG_W-1:0]     cfg_data,
  // pixel channel
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  logic                          frame_start,
  input  logic [bmd_pkg::PIX_W-1:0]     red,
  input  logic [bmd_pkg::PIX_W-1:0]     green,
  input  logic [bmd_pkg::PIX_W-1:0]     blue,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [bmd_pkg::PIX_W-1:0]     movement,
  output logic [bmd_pkg::IDX_W-1:0]     cell_index,
  output logic                          learning,
  output logic                          untracked,
  output logic                          frame_last
);

  import bmd_pkg::*;

  localparam int AW  = $clog2(BG_DEPTH);
  localparam int CHW = PIX_W + FRAC_BITS;
  localparam int UP  = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int DN  = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;

  logic [DIM_W-1:0]   frame_width, frame_height;
  logic [SCALE_W-1:0] scale_log2;
  logic [PIX_W-1:0]   adapt_step, bright_threshold, colour_threshold;

  logic                accept, sampled, upd_can_load, upd_valid, eval_can_load;
  logic [AW-1:0]       cell_addr;
  cell_ctrl_t          scan_ctrl, upd_ctrl, res_ctrl;
  pixel_t              pixel, upd_pix;
  logic [CHW-1:0]      step;
  logic [2:0][CHW-1:0] upd_bg;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= RST_FRAME_WIDTH;
      frame_height     <= RST_FRAME_HEIGHT;
      scale_log2       <= RST_SCALE_LOG2;
      adapt_step       <= RST_ADAPT_STEP;
      bright_threshold <= RST_BRIGHT_TH;
      colour_threshold <= RST_COLOUR_TH;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width      <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height     <= cfg_data;
        CFG_SCALE_LOG2:   scale_log2       <= cfg_data[SCALE_W-1:0];
        CFG_ADAPT_STEP:   adapt_step       <= cfg_data[PIX_W-1:0];
        CFG_BRIGHT_TH:    bright_threshold <= cfg_data[PIX_W-1:0];
        CFG_COLOUR_TH:    colour_threshold <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // step rescaled from 8 fraction bits to FRAC_BITS
  assign step      = (CHW'(adapt_step) << UP) >> DN;

  assign pixel     = {blue, green, red};
  assign pix_stall = !upd_can_load;
  assign accept    = pix_valid && !pix_stall;

  bmd_scan #(
    .BG_DEPTH (BG_DEPTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_start  (frame_start),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .scale_log2   (scale_log2),
    .sampled      (sampled),
    .addr         (cell_addr),
    .ctrl         (scan_ctrl)
  );

  bmd_update #(
    .BG_DEPTH  (BG_DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && sampled),
    .load_addr (cell_addr),
    .load_ctrl (scan_ctrl),
    .load_pix  (pixel),
    .step      (step),
    .can_load  (upd_can_load),
    .out_valid (upd_valid),
    .out_take  (eval_can_load),
    .out_bg    (upd_bg),
    .out_ctrl  (upd_ctrl),
    .out_pix   (upd_pix)
  );

  bmd_eval #(
    .FRAC_BITS (FRAC_BITS)
  ) u_eval (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (upd_valid),
    .can_load         (eval_can_load),
    .in_bg            (upd_bg),
    .in_ctrl          (upd_ctrl),
    .in_pix           (upd_pix),
    .bright_threshold (bright_threshold),
    .colour_threshold (colour_threshold),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .movement         (movement),
    .res_ctrl         (res_ctrl)
  );

  assign cell_index = res_ctrl.index;
  assign learning   = res_ctrl.learning;
  assign untracked  = res_ctrl.untracked;
  assign frame_last = res_ctrl.last;

`ifndef NO_ASSERTIONS
  // input backs up only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> res_valid && res_stall)
    else $error("pixel stall while pipeline has room");

  a_no_motion_learning: assert property (@(posedge clk) disable iff (rst)
    res_valid && (learning || untracked) |-> movement == '0)
    else $error("movement reported while learning or untracked");

  a_untracked_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && untracked |-> cell_index == '0)
    else $error("untracked cell with nonzero index");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for background_motion_detector_top. Pixels go in as
// transactions. A monitor on accepted pixels runs a behavioral copy of the
// background tracker and queues the expected cell result. Each accepted
// result is checked against the head of that queue. Both channels idle and
// stall in random bursts. One test holds off the result side long enough
// to back the pipeline up into the pixel input.
// ----------------------------------------------------------------------------

module tb;
  import bmd_pkg::*;

  localparam int BG_DEPTH     = BG_DEPTH_DEF;
  localparam int FRAC_BITS    = FRAC_BITS_DEF;
  localparam int TOP_BG       = 255 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_ITEMS  = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SCENE_SIZE   = 1024;
  localparam longint TIMEOUT_NS = 64'd30_000_000;

  typedef struct packed {
    logic [PIX_W-1:0] movement;
    logic [IDX_W-1:0] index;
    logic             learning;
    logic             untracked;
    logic             last;
  } cell_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               pix_valid;
  logic               pix_stall;
  logic               frame_start;
  logic [PIX_W-1:0]   red;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   blue;
  logic               res_valid;
  logic               res_stall;
  logic [PIX_W-1:0]   movement;
  logic [IDX_W-1:0]   cell_index;
  logic               learning;
  logic               untracked;
  logic               frame_last;

  background_motion_detector_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .frame_start  (frame_start),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .movement     (movement),
    .cell_index   (cell_index),
    .learning     (learning),
    .untracked    (untracked),
    .frame_last   (frame_last)
  );

  // tracker state
  int unsigned        bg_store [0:BG_DEPTH-1][0:2];
  int unsigned        row_cnt;
  int unsigned        col_cnt;
  int unsigned        cell_cnt;
  logic               first_frame;
  logic [DIM_W-1:0]   reg_width;
  logic [DIM_W-1:0]   reg_height;
  logic [SCALE_W-1:0] reg_scale;
  logic [PIX_W-1:0]   reg_step;
  logic [PIX_W-1:0]   reg_bright_th;
  logic [PIX_W-1:0]   reg_colour_th;

  cell_result_t       expected_cells [$];
  int                 fail_count;
  bit                 quiet;
  bit                 long_hold;

  logic [PIX_W-1:0]   scene [0:SCENE_SIZE-1][0:2];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned abs_gap(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [PIX_W-1:0] jitter(input logic [PIX_W-1:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 8)) - 4;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[PIX_W-1:0];
  endfunction

  // Behavioral background tracker: one call per accepted pixel.
  task automatic track_pixel(input logic fs, input logic [PIX_W-1:0] r, g, b);
    int unsigned w, h, sf, msk, row, col, st, sum, bgsum, mag, colch, p, cur;
    int unsigned px [0:2];
    int d [0:2];
    int ch;
    cell_result_t res;
    w = clamp_dim(reg_width);
    h = clamp_dim(reg_height);
    sf = 1 << reg_scale;
    msk = sf - 1;
    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
      cell_cnt = 0;
    end
    px[0] = r;
    px[1] = g;
    px[2] = b;
    row = row_cnt;
    col = col_cnt;
    if ((row & msk) == 0 && (col & msk) == 0) begin
      res = '0;
      res.learning = first_frame;
      res.last = (row + sf >= h) && (col + sf >= w);
      if (cell_cnt >= BG_DEPTH) begin
        res.untracked = 1'b1;
      end else begin
        res.index = cell_cnt[IDX_W-1:0];
        if (first_frame) begin
          for (ch = 0; ch < 3; ch++) bg_store[cell_cnt][ch] = px[ch] << FRAC_BITS;
        end else begin
          st = (FRAC_BITS >= 8) ? reg_step << (FRAC_BITS - 8) : reg_step >> (8 - FRAC_BITS);
          sum = 0;
          bgsum = 0;
          for (ch = 0; ch < 3; ch++) begin
            p = px[ch] << FRAC_BITS;
            cur = bg_store[cell_cnt][ch];
            if (p > cur && cur < TOP_BG) cur = cur + st;
            else if (p < cur && cur > 0) cur = (cur > st) ? cur - st : 0;
            bg_store[cell_cnt][ch] = cur;
            // truncate toward zero
            d[ch] = (p >= cur) ? int'((p - cur) >> FRAC_BITS) : -int'((cur - p) >> FRAC_BITS);
            sum += px[ch];
            bgsum += cur;
          end
          colch = abs_gap(d[0], d[1]) + abs_gap(d[1], d[2]) + abs_gap(d[2], d[0]);
          if (colch > 255) colch = 255;
          sum = sum << FRAC_BITS;
          mag = (sum >= bgsum) ? sum - bgsum : bgsum - sum;
          if (colch > reg_colour_th && (mag >> FRAC_BITS) / 3 > reg_bright_th)
            res.movement = PIX_W'((px[0] + px[1] + px[2]) / 3);
        end
        cell_cnt++;
      end
      expected_cells.push_back(res);
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      if (row + 1 >= h) begin
        row_cnt = 0;
        cell_cnt = 0;
        first_frame = 1'b0;
      end else begin
        row_cnt = row + 1;
      end
    end else begin
      col_cnt = col + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) track_pixel(frame_start, red, green, blue);
  end

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_cells.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("tb: unexpected result movement=%0d index=%0d", movement, cell_index);
      end else begin
        want = expected_cells.pop_front();
        if (movement !== want.movement || cell_index !== want.index ||
            learning !== want.learning || untracked !== want.untracked ||
            frame_last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("tb: mismatch exp mv=%0d idx=%0d lrn=%0b unt=%0b last=%0b got mv=%0d idx=%0d lrn=%0b unt=%0b last=%0b",
                     want.movement, want.index, want.learning, want.untracked, want.last,
                     movement, cell_index, learning, untracked, frame_last);
        end
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_side
    int n;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        res_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic fs, input logic [PIX_W-1:0] r, g, b);
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      pix_valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk);
    end
    pix_valid   <= 1'b1;
    frame_start <= fs;
    red         <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic send_run(input int n, input bit restart, input bit noisy,
                          input logic [PIX_W-1:0] r, g, b);
    int i;
    for (i = 0; i < n; i++) begin
      if (noisy) begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      send_pixel(restart && i == 0, r, g, b);
    end
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  reg_width     = val[DIM_W-1:0];
      CFG_FRAME_HEIGHT: reg_height    = val[DIM_W-1:0];
      CFG_SCALE_LOG2:   reg_scale     = val[SCALE_W-1:0];
      CFG_ADAPT_STEP:   reg_step      = val[PIX_W-1:0];
      CFG_BRIGHT_TH:    reg_bright_th = val[PIX_W-1:0];
      CFG_COLOUR_TH:    reg_colour_th = val[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int w, h, s, st, bt, ct);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_SCALE_LOG2, s);
    write_reg(CFG_ADAPT_STEP, st);
    write_reg(CFG_BRIGHT_TH, bt);
    write_reg(CFG_COLOUR_TH, ct);
  endtask

  // Reset geometry: 640 wide, cells every 16 pixels, still learning.
  task automatic test_default_registers();
    send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
    send_run(15, 0, 1, 0, 0, 0);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_run(15, 0, 1, 0, 0, 0);
    send_pixel(1'b0, 8'd255, 8'd0, 8'd128);
    wait_idle();
  endtask

  // First full frame loads every store entry; the third row is past the store.
  task automatic test_store_load();
    set_regs(2048, 3, 0, 26, 20, 10);
    send_run(2048 * 3, 1, 1, 0, 0, 0);
    wait_idle();
  endtask

  // Step saturation at both ends, threshold extremes.
  task automatic test_adapt_extremes();
    set_regs(4, 2, 0, 255, 0, 0);
    send_run(8, 1, 0, 8'd0, 8'd0, 8'd0);
    send_run(8, 1, 0, 8'd0, 8'd0, 8'd0);
    send_run(8, 1, 0, 8'd255, 8'd255, 8'd255);
    send_run(8, 0, 0, 8'd255, 8'd0, 8'd128);
    wait_idle();
    write_reg(CFG_ADAPT_STEP, 1);
    write_reg(CFG_BRIGHT_TH, 255);
    write_reg(CFG_COLOUR_TH, 255);
    send_run(8, 1, 0, 8'd0, 8'd255, 8'd0);
    wait_idle();
    write_reg(CFG_BRIGHT_TH, 0);
    send_run(8, 1, 0, 8'd255, 8'd0, 8'd255);
    wait_idle();
  endtask

  // Width/height of zero and past the maximum are clamped.
  task automatic test_size_clamp();
    set_regs(0, 4095, 7, 26, 20, 10);
    send_run(300, 1, 1, 0, 0, 0);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 4095);
    write_reg(CFG_FRAME_HEIGHT, 0);
    send_run(2048 + 3, 1, 1, 0, 0, 0);
    wait_idle();
  endtask

  // Geometry shrinks under the counters: the next pixel ends row and frame.
  task automatic test_shrink_mid_frame();
    set_regs(16, 2048, 1, 40, 5, 5);
    send_run(4 * 16 + 10, 1, 1, 0, 0, 0);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 4);
    write_reg(CFG_FRAME_HEIGHT, 3);
    send_run(20, 0, 1, 0, 0, 0);
    wait_idle();
  endtask

  // Tracking frame with more cells than the store holds.
  task automatic test_untracked_cells();
    set_regs(65, 64, 0, 26, 20, 10);
    send_run(65 * 64 + 2, 1, 1, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_result_backpressure();
    set_regs(8, 8, 0, 128, 10, 10);
    long_hold = 1'b1;
    send_run(64, 1, 1, 0, 0, 0);
    wait_idle();
  endtask

  // Mostly stable scenes with jitter and random outlier pixels, a few broken frames.
  task automatic test_random_scenes();
    int sent, w, h, s, frames, f, pos, npix, i;
    logic fs;
    logic [PIX_W-1:0] r, g, b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      h = $urandom_range(1, 10);
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
      set_regs(w, h, s, $urandom_range(1, 255),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40));
      npix = w * h;
      for (pos = 0; pos < npix; pos++) begin
        for (i = 0; i < 3; i++) begin
          case ($urandom_range(0, 7))
            0: scene[pos][i] = 8'd0;
            1: scene[pos][i] = 8'd255;
            default: scene[pos][i] = $urandom_range(0, 255);
          endcase
        end
      end
      frames = $urandom_range(2, 5);
      for (f = 0; f < frames; f++) begin
        for (pos = 0; pos < npix; pos++) begin
          if (pos == 0) fs = ($urandom_range(0, 2) != 0);
          else fs = ($urandom_range(0, 59) == 0);
          if ($urandom_range(0, 5) == 0) begin
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
          end else begin
            r = jitter(scene[pos][0]);
            g = jitter(scene[pos][1]);
            b = jitter(scene[pos][2]);
          end
          send_pixel(fs, r, g, b);
          sent++;
          // occasionally cut a frame short
          if (pos > 0 && $urandom_range(0, 199) == 0) break;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_FRAME_WIDTH;
    cfg_data     = '0;
    pix_valid    = 1'b0;
    frame_start  = 1'b0;
    red          = '0;
    green        = '0;
    blue         = '0;
    fail_count   = 0;
    quiet        = 1'b0;
    long_hold    = 1'b0;
    row_cnt      = 0;
    col_cnt      = 0;
    cell_cnt     = 0;
    first_frame  = 1'b1;
    reg_width     = RST_FRAME_WIDTH;
    reg_height    = RST_FRAME_HEIGHT;
    reg_scale     = RST_SCALE_LOG2;
    reg_step      = RST_ADAPT_STEP;
    reg_bright_th = RST_BRIGHT_TH;
    reg_colour_th = RST_COLOUR_TH;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_store_load();
    test_adapt_extremes();
    test_size_clamp();
    test_shrink_mid_frame();
    test_untracked_cells();
    test_result_backpressure();
    test_random_scenes();

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_cells.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
